FILE: rtl/amgt_pkg.sv
`default_nettype none

package amgt_pkg;

   localparam int DEFAULT_VERTICES = 16;
   localparam int OP_W             = 2;
   localparam int STATUS_W         = 2;
   localparam int FIELD_W          = 6;
   localparam int MAX_RESULTS      = 16;
   localparam int RES_IDX_W        = $clog2(MAX_RESULTS);
   localparam int COUNT_W          = $clog2(MAX_RESULTS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT,
      OP_REMOVE,
      OP_DFS,
      OP_BFS
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK,
      STS_OUT_OF_RANGE,
      STS_ALREADY,
      STS_NEVER
   } status_type;

   typedef enum logic [2:0] {
      RD_A,
      RD_B,
      RD_PICK,
      RD_POP,
      RD_HEAD
   } rd_sel_type;

   typedef enum logic {
      WR_A,
      WR_B
   } wr_sel_type;

   typedef enum logic [1:0] {
      SEND_STATUS,
      SEND_PEND_MID,
      SEND_PEND_LAST,
      SEND_HEAD
   } send_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_TEST,
      S_READ_B,
      S_WRITE_B,
      S_SINGLE,
      S_DFS_SCAN,
      S_DFS_END,
      S_BFS_READ,
      S_BFS_SCAN,
      S_BFS_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       status_set;
      status_type status_code;
      logic       send;
      send_type   send_kind;
      logic       dfs_start;
      logic       dfs_push;
      logic       dfs_pop;
      logic       bfs_start;
      logic       bfs_enq;
      logic       bfs_deq;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   a_bad;
      logic   b_bad;
      logic   linked;
      logic   cand_any;
      logic   sp_zero;
      logic   count_full;
      logic   bfs_last;
      logic   out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: rtl/amgt_ctrl.sv
`default_nettype none

module amgt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire amgt_pkg::ctrl_status_type stat,
   output amgt_pkg::ctrl_cmd_type         cmd
);
   import amgt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op == OP_INSERT || stat.op == OP_REMOVE) begin
               if (stat.a_bad || stat.b_bad) begin
                  cmd.status_set  = 1'b1;
                  cmd.status_code = STS_OUT_OF_RANGE;
                  state_in        = S_SINGLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_A;
                  state_in   = S_TEST;
               end
            end else if (stat.a_bad) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STS_OUT_OF_RANGE;
               state_in        = S_SINGLE;
            end else if (stat.op == OP_DFS) begin
               cmd.dfs_start = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_A;
               state_in      = S_DFS_SCAN;
            end else begin
               cmd.bfs_start = 1'b1;
               state_in      = S_BFS_READ;
            end
         end
         S_TEST: begin
            if (stat.op == OP_INSERT && stat.linked) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STS_ALREADY;
               state_in        = S_SINGLE;
            end else if (stat.op == OP_REMOVE && !stat.linked) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STS_NEVER;
               state_in        = S_SINGLE;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_A;
               state_in   = S_READ_B;
            end
         end
         S_READ_B: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_B;
            state_in   = S_WRITE_B;
         end
         S_WRITE_B: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = WR_B;
            cmd.status_set  = 1'b1;
            cmd.status_code = STS_OK;
            state_in        = S_SINGLE;
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               cmd.send      = 1'b1;
               cmd.send_kind = SEND_STATUS;
               state_in      = S_IDLE;
            end
         end
         S_DFS_SCAN: begin
            priority if (stat.count_full) begin
               state_in = S_DFS_END;
            end else if (stat.cand_any) begin
               if (stat.out_free) begin
                  cmd.send      = 1'b1;
                  cmd.send_kind = SEND_PEND_MID;
                  cmd.dfs_push  = 1'b1;
                  cmd.rd_en     = 1'b1;
                  cmd.rd_sel    = RD_PICK;
               end
            end else if (stat.sp_zero) begin
               state_in = S_DFS_END;
            end else begin
               cmd.dfs_pop = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_POP;
            end
         end
         S_DFS_END: begin
            if (stat.out_free) begin
               cmd.send      = 1'b1;
               cmd.send_kind = SEND_PEND_LAST;
               state_in      = S_IDLE;
            end
         end
         S_BFS_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HEAD;
            state_in   = S_BFS_SCAN;
         end
         S_BFS_SCAN: begin
            if (stat.cand_any) begin
               cmd.bfs_enq = 1'b1;
            end else begin
               state_in = S_BFS_EMIT;
            end
         end
         S_BFS_EMIT: begin
            if (stat.out_free) begin
               cmd.send      = 1'b1;
               cmd.send_kind = SEND_HEAD;
               cmd.bfs_deq   = 1'b1;
               state_in      = stat.bfs_last ? S_IDLE : S_BFS_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/amgt_datapath.sv
`default_nettype none

module amgt_datapath #(
   parameter int VERTICES = amgt_pkg::DEFAULT_VERTICES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [amgt_pkg::OP_W-1:0]    req_operation,
   input  wire logic [amgt_pkg::FIELD_W-1:0] req_vertex_a,
   input  wire logic [amgt_pkg::FIELD_W-1:0] req_vertex_b,
   input  wire amgt_pkg::ctrl_cmd_type       cmd,
   output amgt_pkg::ctrl_status_type         stat,
   input  wire logic                         rsp_tready,
   output logic                              rsp_tvalid,
   output logic [amgt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [amgt_pkg::FIELD_W-1:0]      rsp_vertex,
   output logic                              rsp_last
);
   import amgt_pkg::*;

   localparam int VW = $clog2(VERTICES);
   localparam int TW = $clog2(VERTICES + 1);
   localparam logic [FIELD_W:0] VERTEX_LIMIT = (FIELD_W + 1)'(VERTICES);

   op_type                op_ff;
   logic [FIELD_W-1:0]    a_ff;
   logic [FIELD_W-1:0]    b_ff;
   status_type            status_ff;

   logic [VERTICES-1:0]   adj_mem [VERTICES];
   logic [VERTICES-1:0]   row_valid_ff;
   logic [VERTICES-1:0]   rd_data_ff;
   logic                  rd_valid_ff;

   logic [VERTICES-1:0]   visited_ff;
   logic [VERTICES-1:0]   seen_ff;
   logic [VW-1:0]         pend_ff;
   logic [VW-1:0]         cur_ff;
   logic [VW-1:0]         stack_ff [MAX_RESULTS];
   logic [RES_IDX_W-1:0]  sp_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [VW-1:0]         queue_ff [MAX_RESULTS];
   logic [RES_IDX_W-1:0]  head_ff;
   logic [TW-1:0]         tail_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [FIELD_W-1:0]    rsp_vertex_ff;
   logic                  rsp_last_ff;

   logic [VW-1:0]         a_idx;
   logic [VW-1:0]         b_idx;
   logic [VERTICES-1:0]   a_oh;
   logic [VERTICES-1:0]   row;
   logic [VERTICES-1:0]   cand;
   logic [VERTICES-1:0]   pick_oh;
   logic [VW-1:0]         pick;
   logic [RES_IDX_W-1:0]  sp_dec;
   logic [VW-1:0]         stack_top;
   logic [VW-1:0]         head_v;
   logic [VW-1:0]         rd_addr;
   logic [VW-1:0]         wr_addr;
   logic [VW-1:0]         wr_bit;
   logic [VERTICES-1:0]   wr_oh;
   logic [VERTICES-1:0]   wr_data;
   logic                  bfs_last;
   logic                  out_free;

   assign a_idx     = a_ff[VW-1:0];
   assign b_idx     = b_ff[VW-1:0];
   assign a_oh      = VERTICES'(1) << a_idx;
   assign row       = rd_valid_ff ? rd_data_ff : '0;
   assign cand      = row & ~((op_ff == OP_DFS) ? visited_ff : seen_ff);
   assign pick_oh   = cand & (~cand + VERTICES'(1));
   assign sp_dec    = sp_ff - RES_IDX_W'(1);
   assign stack_top = stack_ff[sp_dec];
   assign head_v    = queue_ff[head_ff];
   assign bfs_last  = (head_ff == RES_IDX_W'(MAX_RESULTS - 1))
                      || ((8'(head_ff) + 8'd1) == 8'(tail_ff));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pick = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick = VW'(i);
         end
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_A:    rd_addr = a_idx;
         RD_B:    rd_addr = b_idx;
         RD_PICK: rd_addr = pick;
         RD_POP:  rd_addr = stack_top;
         RD_HEAD: rd_addr = head_v;
         default: rd_addr = a_idx;
      endcase
   end

   assign wr_addr = (cmd.wr_sel == WR_A) ? a_idx : b_idx;
   assign wr_bit  = (cmd.wr_sel == WR_A) ? b_idx : a_idx;
   assign wr_oh   = VERTICES'(1) << wr_bit;
   assign wr_data = (op_ff == OP_INSERT) ? (row | wr_oh) : (row & ~wr_oh);

   always_comb begin
      stat.op         = op_ff;
      stat.a_bad      = {1'b0, a_ff} >= VERTEX_LIMIT;
      stat.b_bad      = {1'b0, b_ff} >= VERTEX_LIMIT;
      stat.linked     = row[b_idx];
      stat.cand_any   = |cand;
      stat.sp_zero    = (sp_ff == '0);
      stat.count_full = (count_ff == COUNT_W'(MAX_RESULTS));
      stat.bfs_last   = bfs_last;
      stat.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_operation);
         a_ff  <= req_vertex_a;
         b_ff  <= req_vertex_b;
      end
      if (cmd.status_set) begin
         status_ff <= cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
      end else if (cmd.dfs_start) begin
         visited_ff <= a_oh;
      end else if (cmd.dfs_push) begin
         visited_ff <= visited_ff | pick_oh;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dfs_start) begin
         pend_ff  <= a_idx;
         cur_ff   <= a_idx;
         sp_ff    <= '0;
         count_ff <= COUNT_W'(1);
      end else if (cmd.dfs_push) begin
         stack_ff[sp_ff] <= cur_ff;
         sp_ff           <= sp_ff + RES_IDX_W'(1);
         cur_ff          <= pick;
         pend_ff         <= pick;
         count_ff        <= count_ff + COUNT_W'(1);
      end else if (cmd.dfs_pop) begin
         cur_ff <= stack_top;
         sp_ff  <= sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bfs_start) begin
         queue_ff[0] <= a_idx;
         seen_ff     <= a_oh;
         head_ff     <= '0;
         tail_ff     <= TW'(1);
      end else begin
         if (cmd.bfs_enq) begin
            if (int'(tail_ff) < MAX_RESULTS) begin
               queue_ff[RES_IDX_W'(tail_ff)] <= pick;
            end
            seen_ff <= seen_ff | pick_oh;
            tail_ff <= tail_ff + TW'(1);
         end
         if (cmd.bfs_deq) begin
            head_ff <= head_ff + RES_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         unique case (cmd.send_kind)
            SEND_STATUS: begin
               rsp_status_ff <= status_ff;
               rsp_vertex_ff <= '0;
               rsp_last_ff   <= 1'b1;
            end
            SEND_PEND_MID: begin
               rsp_status_ff <= STS_OK;
               rsp_vertex_ff <= FIELD_W'(pend_ff);
               rsp_last_ff   <= 1'b0;
            end
            SEND_PEND_LAST: begin
               rsp_status_ff <= STS_OK;
               rsp_vertex_ff <= FIELD_W'(pend_ff);
               rsp_last_ff   <= 1'b1;
            end
            SEND_HEAD: begin
               rsp_status_ff <= STS_OK;
               rsp_vertex_ff <= FIELD_W'(head_v);
               rsp_last_ff   <= bfs_last;
            end
            default: begin
               rsp_status_ff <= status_ff;
               rsp_vertex_ff <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/adjacency_matrix_graph_traversal_core.sv
`default_nettype none

// Undirected graph engine over a symmetric adjacency bit matrix of VERTICES rows, held in a
// memory with one read and one write port and a valid bit per row, so the graph is empty
// right after reset with no clearing pass. An insert or remove transfer yields one status
// result once each endpoint's row has been read and then written in turn. A depth-first
// walk reads one row per cycle, one for each visited vertex and one for each backtrack,
// but holds while a found neighbor waits for room in the output register. A breadth-first
// walk, for each dequeued vertex, reads its row, queues each newly found neighbor in turn,
// closes the scan and emits the vertex. A walk emits at most 16 results, the last one with
// tlast set; a new request is taken while the final result still waits in the output
// register.
module adjacency_matrix_graph_traversal_core #(
   parameter int VERTICES = amgt_pkg::DEFAULT_VERTICES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // operation [1:0], vertex_a [7:2], vertex_b [13:8]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // status [1:0], vertex [7:2]
   output logic             rsp_tlast
);
   import amgt_pkg::*;

   ctrl_cmd_type        cmd;
   ctrl_status_type     stat;
   logic [STATUS_W-1:0] rsp_status;
   logic [FIELD_W-1:0]  rsp_vertex;

   amgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   amgt_datapath #(
      .VERTICES (VERTICES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_tdata[1:0]),
      .req_vertex_a  (req_tdata[7:2]),
      .req_vertex_b  (req_tdata[13:8]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_vertex    (rsp_vertex),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {rsp_vertex, rsp_status};

endmodule

`default_nettype wire

FILE: test/adjacency_matrix_graph_traversal_core_test.sv
`timescale 1ns / 1ps

module adjacency_matrix_graph_traversal_core_test;
   import amgt_pkg::*;

   localparam int VERTICES   = DEFAULT_VERTICES;
   localparam int VW         = $clog2(VERTICES);
   localparam int IDLE_LIMIT = 3000;
   localparam int RANDOM_REQS = 340;

   typedef struct {
      op_type     op;
      logic [5:0] vtx_a;
      logic [5:0] vtx_b;
      bit         drain_first;
   } graph_req_type;

   typedef struct {
      status_type status;
      logic [5:0] vertex;
      logic       last;
   } graph_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // operation [1:0], vertex_a [7:2], vertex_b [13:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // status [1:0], vertex [7:2]
   logic        rsp_tlast;

   graph_req_type pending_reqs [$];
   graph_rsp_type expected_rsps [$];

   logic [VERTICES-1:0] graph_rows [VERTICES];
   logic [VERTICES-1:0] visited_mask;

   int error_count   = 0;
   int accepted_reqs = 0;
   int checked_rsps  = 0;
   int gap_left      = 0;
   int stall_left    = 0;
   int idle_cycles   = 0;
   graph_req_type active_req;

   adjacency_matrix_graph_traversal_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_pause(input bit calm);
      if (calm) begin
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic void push_single(input status_type status);
      expected_rsps.push_back('{status: status, vertex: 6'd0, last: 1'b1});
   endfunction

   function automatic void push_walk(input logic [5:0] order [$]);
      foreach (order[k]) begin
         expected_rsps.push_back('{status: STS_OK, vertex: order[k],
                                   last: (k == order.size() - 1)});
      end
   endfunction

   function automatic void walk_depth_first(input logic [5:0] start);
      logic [5:0] order [$];
      logic [5:0] stack_vtx [VERTICES];
      int         stack_next [VERTICES];
      int         depth;
      int         nbr;
      logic [5:0] vtx;
      visited_mask            = '0;
      visited_mask[VW'(start)] = 1'b1;
      order.push_back(start);
      stack_vtx[0]  = start;
      stack_next[0] = 0;
      depth = 1;
      while (depth > 0 && order.size() < MAX_RESULTS) begin
         vtx = stack_vtx[VW'(depth-1)];
         nbr = stack_next[VW'(depth-1)];
         if (nbr >= VERTICES) begin
            depth--;
         end else begin
            stack_next[VW'(depth-1)] = nbr + 1;
            if (graph_rows[VW'(vtx)][VW'(nbr)] && !visited_mask[VW'(nbr)]) begin
               visited_mask[VW'(nbr)] = 1'b1;
               order.push_back(nbr[5:0]);
               if (depth < VERTICES) begin
                  stack_vtx[VW'(depth)]  = nbr[5:0];
                  stack_next[VW'(depth)] = 0;
                  depth++;
               end
            end
         end
      end
      push_walk(order);
   endfunction

   function automatic void walk_breadth_first(input logic [5:0] start);
      logic [5:0]          order [$];
      logic [5:0]          frontier [$];
      logic [VERTICES-1:0] seen;
      logic [5:0]          vtx;
      int                  head;
      seen             = '0;
      seen[VW'(start)] = 1'b1;
      frontier.push_back(start);
      head = 0;
      while (head < frontier.size() && order.size() < MAX_RESULTS) begin
         vtx = frontier[head];
         for (int nbr = 0; nbr < VERTICES; nbr++) begin
            if (graph_rows[VW'(vtx)][VW'(nbr)] && !seen[VW'(nbr)]) begin
               seen[VW'(nbr)] = 1'b1;
               frontier.push_back(nbr[5:0]);
            end
         end
         head++;
         order.push_back(vtx);
      end
      push_walk(order);
   endfunction

   function automatic void predict_response(input graph_req_type r);
      logic linked;
      if (r.op == OP_INSERT || r.op == OP_REMOVE) begin
         if (r.vtx_a >= VERTICES || r.vtx_b >= VERTICES) begin
            push_single(STS_OUT_OF_RANGE);
            return;
         end
         linked = graph_rows[VW'(r.vtx_a)][VW'(r.vtx_b)];
         if (r.op == OP_INSERT && linked) begin
            push_single(STS_ALREADY);
         end else if (r.op == OP_REMOVE && !linked) begin
            push_single(STS_NEVER);
         end else begin
            graph_rows[VW'(r.vtx_a)][VW'(r.vtx_b)] = (r.op == OP_INSERT);
            graph_rows[VW'(r.vtx_b)][VW'(r.vtx_a)] = (r.op == OP_INSERT);
            push_single(STS_OK);
         end
      end else if (r.vtx_a >= VERTICES) begin
         push_single(STS_OUT_OF_RANGE);
      end else if (r.op == OP_DFS) begin
         walk_depth_first(r.vtx_a);
      end else begin
         walk_breadth_first(r.vtx_a);
      end
   endfunction

   function automatic void add_req(input op_type op, input int a, input int b,
                                   input bit drain_first = 1'b0);
      pending_reqs.push_back('{op: op, vtx_a: a[5:0], vtx_b: b[5:0],
                               drain_first: drain_first});
   endfunction

   function automatic graph_req_type random_req(input int idx);
      graph_req_type r;
      int            pick;
      int            insert_share;
      int            remove_share;
      pick = $urandom_range(0, 99);
      case ((idx / 120) % 3)
         0: begin
            insert_share = 55;
            remove_share = 10;
         end
         1: begin
            insert_share = 25;
            remove_share = 40;
         end
         default: begin
            insert_share = 60;
            remove_share = 8;
         end
      endcase
      r.vtx_a       = 6'($urandom_range(0, VERTICES - 1));
      r.vtx_b       = 6'($urandom_range(0, VERTICES - 1));
      r.drain_first = (idx % 90 == 45);
      if (pick < 8) begin
         r.op    = op_type'($urandom_range(0, 3));
         r.vtx_a = 6'($urandom_range(0, 63));
         r.vtx_b = 6'($urandom_range(0, 63));
      end else if (pick < 8 + insert_share) begin
         r.op = OP_INSERT;
      end else if (pick < 8 + insert_share + remove_share) begin
         r.op = OP_REMOVE;
      end else begin
         r.op    = ($urandom_range(0, 1) != 0) ? OP_DFS : OP_BFS;
         r.vtx_b = 6'($urandom_range(0, 63));
      end
      return r;
   endfunction

   always @(posedge clock) begin : req_driver
      int gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         gap = gap_left;
         if (req_tvalid) begin
            predict_response(active_req);
            accepted_reqs = accepted_reqs + 1;
            gap = draw_pause((accepted_reqs / 40) % 3 == 1);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap - 1;
         end else if (pending_reqs.size() == 0 ||
                      (pending_reqs[0].drain_first &&
                       (expected_rsps.size() != 0 || (rsp_tvalid && rsp_tready)))) begin
            req_tvalid <= 1'b0;
            gap_left   <= 0;
         end else begin
            active_req = pending_reqs.pop_front();
            req_tdata  <= {2'b00, active_req.vtx_b, active_req.vtx_a, active_req.op};
            req_tvalid <= 1'b1;
            gap_left   <= 0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      graph_rsp_type want;
      int            stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         stall = stall_left;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transfer: status %0d vertex %0d last %0b",
                      rsp_tdata[1:0], rsp_tdata[7:2], rsp_tlast);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  error_count++;
               end
               if (rsp_tdata[7:2] !== want.vertex) begin
                  $error("vertex: expected %0d, got %0d", want.vertex, rsp_tdata[7:2]);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
                  error_count++;
               end
            end
            checked_rsps = checked_rsps + 1;
            stall = draw_pause((checked_rsps / 64) % 3 == 2);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (graph_rows[v]) begin
         graph_rows[v] = '0;
      end
      visited_mask = '0;

      // Walks on the empty graph and start vertices out of range.
      add_req(OP_DFS, 0, 63);
      add_req(OP_BFS, VERTICES - 1, 0);
      add_req(OP_DFS, VERTICES, 0);
      add_req(OP_BFS, 63, 63);
      // Edge endpoints out of range on either side.
      add_req(OP_INSERT, 0, 63);
      add_req(OP_INSERT, 63, 0);
      add_req(OP_REMOVE, 42, 21);
      add_req(OP_REMOVE, VERTICES - 1, VERTICES);
      // Self loop set and cleared, with duplicate and missing edge reports, then a small graph built and walked.
      add_req(OP_INSERT, 0, 0);
      add_req(OP_INSERT, 0, 0);
      add_req(OP_REMOVE, 0, 0);
      add_req(OP_REMOVE, 0, 0);
      add_req(OP_REMOVE, 3, 5);
      add_req(OP_INSERT, VERTICES - 1, 0);
      add_req(OP_INSERT, 0, 7);
      add_req(OP_INSERT, 7, VERTICES - 1);
      add_req(OP_INSERT, VERTICES - 1, 7);
      add_req(OP_INSERT, 2, 7);
      add_req(OP_INSERT, 2, 2);
      add_req(OP_DFS, 0, 42, 1'b1);
      add_req(OP_BFS, 0, 21);
      add_req(OP_DFS, VERTICES - 1, 0);
      add_req(OP_BFS, 2, 0);
      add_req(OP_DFS, 9, 63);
      for (int i = 0; i < RANDOM_REQS; i++) begin
         pending_reqs.push_back(random_req(i));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
      repeat (60) @(negedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
